// File: design/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg: shared types and constants for the min-max contrast stretch
// Holds the pixel type, the full-scale level, divider sizing and the
// one-hot sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcs_pkg;

	localparam int unsigned PIX_W = 8;

	typedef logic [PIX_W-1:0] pixel_t;

	localparam pixel_t FULL_SCALE = 8'd255;

	// One quotient bit per divider step.
	localparam int unsigned DIV_STEPS = PIX_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	typedef logic [CNT_W-1:0] step_cnt_t;

	localparam logic REQ_GATHER = 1'b0;
	localparam logic REQ_MAP    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PREP   = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// File: design/min_max_contrast_stretch.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch: two-pass linear contrast stretch of 8-bit pixels
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------
//   input   | in_valid  | in_stall  | req_type, pixel_in
//   output  | out_valid | out_stall | pixel_out
//
// A gather beat updates the low/high statistics; the input stays ready for the next beat.
// A map beat inside the gathered range goes through these steps: the beat is taken,
// (p - low) * 255 is formed, eight steps of the shared restoring
// subtract-compare unit run, and the output register is loaded.
// Map beats on a flat range, at or below low or at or above high skip the divider.
// After reset low is 255, high is 0 and no gather pass is open.
// A held output beat only blocks the block when a new result is ready for it.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_contrast_stretch
	import mmcs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire logic   req_type,
	input  wire pixel_t pixel_in,
	output logic        out_valid,
	input  wire logic   out_stall,
	output pixel_t      pixel_out
);

	state_t    state_q;
	step_cnt_t cnt_q;
	pixel_t    low_q;
	pixel_t    high_q;
	logic      gathering_q;
	pixel_t    diff_q;
	pixel_t    span_q;
	pixel_t    rem_q;
	pixel_t    work_q;
	logic      out_valid_q;
	pixel_t    pixel_out_q;

	logic                 in_take;
	logic                 out_free;
	logic                 out_load;
	logic [2*PIX_W-1:0]   dividend;
	logic [PIX_W+1:0]     trial;
	logic                 qbit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_FINISH) && out_free;
	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

	// (p - low) * 255 as (d << 8) - d.
	assign dividend = {diff_q, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff_q};

	// Shared step: shift in the next dividend bit and try to subtract the span.
	assign trial = {1'b0, rem_q, work_q[PIX_W-1]} - {2'b00, span_q};
	assign qbit  = !trial[PIX_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			low_q       <= FULL_SCALE;
			high_q      <= '0;
			gathering_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take && req_type == REQ_GATHER) begin
						if (!gathering_q) begin
							low_q       <= pixel_in;
							high_q      <= pixel_in;
							gathering_q <= 1'b1;
						end else begin
							if (pixel_in < low_q) begin
								low_q <= pixel_in;
							end
							if (pixel_in > high_q) begin
								high_q <= pixel_in;
							end
						end
					end else if (in_take) begin
						gathering_q <= 1'b0;
						if (high_q <= low_q || pixel_in <= low_q || pixel_in >= high_q) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == step_cnt_t'(DIV_STEPS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				diff_q <= pixel_in - low_q;
				span_q <= high_q - low_q;
				if (high_q <= low_q) begin
					work_q <= pixel_in;
				end else if (pixel_in <= low_q) begin
					work_q <= '0;
				end else begin
					work_q <= FULL_SCALE;
				end
			end
			ST_PREP: begin
				rem_q  <= dividend[2*PIX_W-1:PIX_W];
				work_q <= dividend[PIX_W-1:0];
			end
			ST_DIV: begin
				if (qbit) begin
					rem_q <= trial[PIX_W-1:0];
				end else begin
					rem_q <= {rem_q[PIX_W-2:0], work_q[PIX_W-1]};
				end
				work_q <= {work_q[PIX_W-2:0], qbit};
			end
			ST_FINISH: begin
				if (out_free) begin
					pixel_out_q <= work_q;
				end
			end
			default: begin
				work_q <= work_q;
			end
		endcase
	end

	// The partial remainder always stays below the span, so eight steps
	// give the whole quotient.
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < span_q))
		else $error("divider remainder reached the span");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == step_cnt_t'(DIV_STEPS - 1)) |=> (state_q == ST_FINISH))
		else $error("divider did not finish after its last step");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("output beat raised outside the finish state");

	a_map_closes_gather: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && req_type == REQ_MAP) |=> !gathering_q)
		else $error("map beat left the gather pass open");

	a_stats_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		gathering_q |-> (low_q <= high_q))
		else $error("low level above high level during a gather pass");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking regression for min_max_contrast_stretch
// Sends a directed table of gather and map beats, then randomized frames.
// A frame is a gather pass followed by a map pass, with some noise and
// broken frames mixed in. Every map beat is predicted in the bench and
// compared with the pixel that comes out. The sender works in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top
	import mmcs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BEATS = 925;
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned N_ROWS = 25;

	typedef struct packed {
		logic   rt;
		pixel_t px;
		logic   known;
		pixel_t want;
	} stim_row_t;

	// Rows with known set carry an expected pixel that is plain from the
	// stretch rule; the others are left to the predictor.
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{REQ_MAP,    8'd0,   1'b1, 8'd0},    // nothing gathered: passes unchanged
		'{REQ_MAP,    8'd255, 1'b1, 8'd255},
		'{REQ_MAP,    8'd90,  1'b1, 8'd90},
		'{REQ_GATHER, 8'd100, 1'b0, 8'd0},
		'{REQ_GATHER, 8'd100, 1'b0, 8'd0},
		'{REQ_MAP,    8'd37,  1'b1, 8'd37},   // flat frame
		'{REQ_GATHER, 8'd0,   1'b0, 8'd0},    // restarts the statistics
		'{REQ_GATHER, 8'd255, 1'b0, 8'd0},
		'{REQ_MAP,    8'd0,   1'b1, 8'd0},
		'{REQ_MAP,    8'd255, 1'b1, 8'd255},
		'{REQ_MAP,    8'd128, 1'b1, 8'd128},
		'{REQ_GATHER, 8'd50,  1'b0, 8'd0},
		'{REQ_GATHER, 8'd60,  1'b0, 8'd0},
		'{REQ_MAP,    8'd49,  1'b1, 8'd0},    // below the range
		'{REQ_MAP,    8'd60,  1'b1, 8'd255},
		'{REQ_MAP,    8'd55,  1'b0, 8'd0},
		'{REQ_GATHER, 8'd200, 1'b0, 8'd0},
		'{REQ_GATHER, 8'd10,  1'b0, 8'd0},
		'{REQ_GATHER, 8'd100, 1'b0, 8'd0},
		'{REQ_MAP,    8'd11,  1'b0, 8'd0},
		'{REQ_MAP,    8'd199, 1'b0, 8'd0},
		'{REQ_GATHER, 8'd254, 1'b0, 8'd0},
		'{REQ_GATHER, 8'd255, 1'b0, 8'd0},
		'{REQ_MAP,    8'd254, 1'b1, 8'd0},    // span of one level
		'{REQ_MAP,    8'd255, 1'b1, 8'd255}
	};

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	logic   req_type;
	pixel_t pixel_in;
	logic   out_valid;
	logic   out_stall;
	pixel_t pixel_out;

	// Bench copy of the statistics.
	pixel_t lo_level;
	pixel_t hi_level;
	logic   pass_open;

	pixel_t stretched_q[$];
	pixel_t want_px;

	int unsigned errors;
	int unsigned beats_sent;
	int unsigned gathers;
	int unsigned maps;
	int unsigned flat_maps;
	int unsigned clamped_maps;
	int unsigned pixels_checked;
	int unsigned frames;
	int unsigned burst_left;
	int unsigned cycles;
	int unsigned stall_left;
	int unsigned stall_mode;

	min_max_contrast_stretch uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic stretch_predict(input logic rt, input pixel_t px,
			output pixel_t res);
		pixel_t      diff;
		pixel_t      span;
		logic [15:0] scaled;
		logic [15:0] quot;
		res = '0;
		if (rt == REQ_GATHER) begin
			gathers++;
			if (!pass_open) begin
				lo_level = px;
				hi_level = px;
				pass_open = 1'b1;
			end else begin
				if (px < lo_level)
					lo_level = px;
				if (px > hi_level)
					hi_level = px;
			end
			return 1'b0;
		end
		maps++;
		pass_open = 1'b0;
		if (hi_level <= lo_level) begin
			flat_maps++;
			res = px;
		end else if (px <= lo_level) begin
			clamped_maps++;
			res = '0;
		end else if (px >= hi_level) begin
			clamped_maps++;
			res = FULL_SCALE;
		end else begin
			diff = px - lo_level;
			span = hi_level - lo_level;
			scaled = {8'd0, diff} * {8'd0, FULL_SCALE};
			quot = scaled / {8'd0, span};
			res = (quot > {8'd0, FULL_SCALE}) ? FULL_SCALE : quot[7:0];
		end
		return 1'b1;
	endfunction

	function automatic pixel_t pick_level(input int unsigned lo, input int unsigned hi);
		return pixel_t'($urandom_range(hi, lo));
	endfunction

	function automatic void pixel_checks_inc();
		pixels_checked++;
	endfunction

	// Holds the beat until it is taken, then records what it should produce.
	task automatic send_beat(input logic rt, input pixel_t px, input logic known,
			input pixel_t want);
		pixel_t      res;
		int unsigned gap;
		in_valid <= 1'b1;
		req_type <= rt;
		pixel_in <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (stretch_predict(rt, px, res))
			stretched_q.push_back(known ? want : res);
		beats_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 15);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (stretched_q.size() != 0);
	endtask

	task automatic random_frame();
		int unsigned kind;
		int unsigned lo_b;
		int unsigned hi_b;
		int unsigned n_gather;
		int unsigned n_map;
		int unsigned shape;
		kind = $urandom_range(0, 11);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4))
				send_beat(logic'($urandom_range(0, 1)), pick_level(0, 255), 1'b0, '0);
			return;
		end
		shape = $urandom_range(0, 4);
		if (shape == 0) begin
			lo_b = $urandom_range(0, 255);
			hi_b = (lo_b + $urandom_range(0, 3) > 255) ? 255 : lo_b + $urandom_range(0, 3);
		end else if (shape == 1) begin
			lo_b = 0;
			hi_b = 255;
		end else begin
			lo_b = $urandom_range(0, 255);
			hi_b = $urandom_range(255, lo_b);
		end
		// A frame with no gather maps against the statistics left over.
		n_gather = (kind == 1) ? 0 : $urandom_range(1, 12);
		n_map = $urandom_range(1, 12);
		for (int unsigned i = 0; i < n_gather; i++) begin
			send_beat(REQ_GATHER, pick_level(lo_b, hi_b), 1'b0, '0);
			// A stray map in the middle splits the gather pass in two.
			if (kind == 2 && i == n_gather / 2)
				send_beat(REQ_MAP, pick_level(0, 255), 1'b0, '0);
		end
		for (int unsigned i = 0; i < n_map; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_beat(REQ_MAP, pick_level(0, 255), 1'b0, '0);
			else
				send_beat(REQ_MAP, pick_level(lo_b, hi_b), 1'b0, '0);
		end
		frames++;
	endtask

	// Receiver stall pattern: free runs, short stalls, random chatter and
	// long holds, each for a random stretch.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: stall_left = $urandom_range(10, 60);
				1: stall_left = $urandom_range(1, 3);
				2: stall_left = $urandom_range(10, 40);
				default: stall_left = $urandom_range(10, 25);
			endcase
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			2: out_stall <= logic'($urandom_range(0, 1));
			default: out_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (stretched_q.size() == 0) begin
				errors++;
				$display("%0t: pixel_out %0d arrived with nothing expected", $time, pixel_out);
			end else begin
				want_px = stretched_q.pop_front();
				pixel_checks_inc();
				if (pixel_out !== want_px) begin
					errors++;
					$display("%0t: pixel_out mismatch: expected %0d, actual %0d",
						$time, want_px, pixel_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d pixels still expected", $time, stretched_q.size());
			$display("min_max_contrast_stretch regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_GATHER;
		pixel_in <= '0;
		out_stall <= 1'b0;
		lo_level = 8'd255;
		hi_level = 8'd0;
		pass_open = 1'b0;
		errors = 0;
		beats_sent = 0;
		gathers = 0;
		maps = 0;
		flat_maps = 0;
		clamped_maps = 0;
		pixels_checked = 0;
		frames = 0;
		burst_left = 0;
		cycles = 0;
		stall_left = 0;
		stall_mode = 0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_beat(DIRECTED[i].rt, DIRECTED[i].px, DIRECTED[i].known, DIRECTED[i].want);
		drain_results();

		while (beats_sent < N_ROWS + RANDOM_BEATS) begin
			random_frame();
			if (frames % 8 == 7)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Sent %0d beats (%0d gather, %0d map) in %0d random frames.",
			beats_sent, gathers, maps, frames);
		$display("Checked %0d pixels: %0d on a flat range, %0d clamped at an end.",
			pixels_checked, flat_maps, clamped_maps);
		if (errors == 0) begin
			$display("min_max_contrast_stretch regression: pass");
		end else begin
			$display("%0d errors", errors);
			$display("min_max_contrast_stretch regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/mmcs_pkg.sv
design/min_max_contrast_stretch.sv
tb/tb_top.sv
